### rtl/sdrt_pkg.sv
// ----------------------------------------------------------------------------
// sdrt_pkg
// Shared types, codes and small helpers of the sprite dirty-rectangle tracker.
// ----------------------------------------------------------------------------
package sdrt_pkg;

    localparam int SDRT_SPRITES   = 8;
    localparam int SDRT_MARGIN    = 8;
    localparam int MAX_RESULTS    = 16;
    localparam int CFG_IDX_W      = 1;
    localparam logic [15:0] EVEN_MASK = 16'hFFFE;
    localparam logic [15:0] MAPW_RST  = 16'd160;
    localparam logic [15:0] MAPH_RST  = 16'd100;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_W = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_H = 1'b1;

    localparam logic [2:0] CMD_ENABLE  = 3'd0;
    localparam logic [2:0] CMD_DISABLE = 3'd1;
    localparam logic [2:0] CMD_IMAGE   = 3'd2;
    localparam logic [2:0] CMD_MOVE    = 3'd3;
    localparam logic [2:0] CMD_DIRTY   = 3'd4;
    localparam logic [2:0] CMD_COMMIT  = 3'd5;

    localparam logic [1:0] RK_NONE  = 2'd0;
    localparam logic [1:0] RK_DRAW  = 2'd1;
    localparam logic [1:0] RK_ERASE = 2'd2;

    typedef enum logic [2:0] {
        ST_INACTIVE    = 3'd0,
        ST_DISABLING   = 3'd1,
        ST_ACTIVE      = 3'd2,
        ST_MOVING      = 3'd3,
        ST_POSITIONING = 3'd4
    } t_status;

    typedef struct packed {
        logic [2:0]         command;
        logic [2:0]         sprite_index;
        logic signed [15:0] pos_s;
        logic signed [15:0] pos_t;
        logic [7:0]         size_w;
        logic [7:0]         size_h;
        logic [15:0]        image_handle;
    } t_in;

    typedef struct packed {
        logic        accepted;
        logic [15:0] out_s;
        logic [15:0] out_t;
        logic [1:0]  rect_kind;
        logic [2:0]  rect_sprite;
        logic [15:0] rect_s;
        logic [15:0] rect_t;
        logic [8:0]  rect_w;
        logic [8:0]  rect_h;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [15:0] s;
        logic [15:0] t;
        logic [8:0]  w;
        logic [8:0]  h;
    } t_rect;

    // width of an even-aligned span from lo to hi+w
    function automatic logic [8:0] span_w(logic [15:0] lo, logic [15:0] hi,
                                          logic [7:0] w);
        logic [16:0] e;
        e = ({1'b0, hi} + {9'd0, w} + 17'd1) & ~17'd1;
        return 9'(e - {1'b0, lo & EVEN_MASK});
    endfunction

    function automatic logic rect_hit(t_rect a, t_rect b);
        return ({1'b0, a.s} < ({1'b0, b.s} + {8'd0, b.w})) &&
               (({1'b0, a.s} + {8'd0, a.w}) > {1'b0, b.s}) &&
               ({1'b0, a.t} < ({1'b0, b.t} + {8'd0, b.h})) &&
               (({1'b0, a.t} + {8'd0, a.h}) > {1'b0, b.t});
    endfunction

endpackage

### rtl/sprite_dirty_rect_tracker_core.sv
// ----------------------------------------------------------------------------
// sprite_dirty_rect_tracker_core
// Sprite table with status and redraw rectangles, driven by a command sequencer.
// ----------------------------------------------------------------------------
// Steps: enable clamps s, t, writes the entry; move clamps s, t, takes deltas,
//   writes spans; dirty rect tests each entry; commit checks overlaps, then erase
//   and draw per entry; it tests pairs j < i per active i, one pair per cycle.
// Throughput: one command at a time; ready is high only in idle. Each command
//   ends with one word in the output register; commit pushes one word per rect,
//   and output stalls add to the commit time.
// Reset: synchronous, active low; all sprites inactive, map 160 x 100.
// ----------------------------------------------------------------------------
module sprite_dirty_rect_tracker_core #(
    parameter int SPRITE_COUNT = sdrt_pkg::SDRT_SPRITES,
    parameter int MOVE_MARGIN  = sdrt_pkg::SDRT_MARGIN
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  sdrt_pkg::t_in                  i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output sdrt_pkg::t_out                 o_out,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [sdrt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                    i_cfg_data
);
    import sdrt_pkg::*;

    localparam int IW = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
    localparam int CW = $clog2(SPRITE_COUNT + 1);
    localparam logic [CW-1:0] LAST_I = CW'(SPRITE_COUNT);
    localparam logic signed [16:0] MM = 17'(MOVE_MARGIN);

    typedef enum logic [4:0] {
        S_IDLE, S_EN_S, S_EN_T, S_EN_WR, S_DIS, S_IMG,
        S_MV_S, S_MV_T, S_MV_D, S_MV_X, S_MV_Y,
        S_DR, S_CM_I, S_CM_J, S_CM_E, S_CM_D, S_FIN
    } t_state;

    t_state r_state;

    // sprite table
    t_status     r_stat [SPRITE_COUNT];
    logic [7:0]  r_sw   [SPRITE_COUNT];
    logic [7:0]  r_sh   [SPRITE_COUNT];
    logic [15:0] r_ss   [SPRITE_COUNT];
    logic [15:0] r_st   [SPRITE_COUNT];
    t_rect       r_buf  [SPRITE_COUNT];
    t_rect       r_ers  [SPRITE_COUNT];

    logic [15:0] r_mapw, r_maph;
    t_in         r_in;
    logic [15:0] r_s, r_t;
    logic        r_near, r_skip, r_dsle, r_dtle;
    logic [CW-1:0] r_i, r_j;
    logic [4:0]  r_cnt;
    logic        r_acc;
    logic [15:0] r_os, r_ot;
    t_rect       r_cur;
    t_out        r_pend;
    logic        r_pend_v;
    t_out        r_out;
    logic        r_out_v;

    // single read port into the table
    logic [IW-1:0] w_ra;
    t_status       w_st;
    logic [7:0]    w_sw, w_sh;
    logic [15:0]   w_ss, w_sst;
    t_rect         w_buf;
    t_rect         w_ers;
    logic          w_idx_ok;

    always_comb begin
        unique case (r_state)
            S_DR, S_CM_I, S_CM_E, S_CM_D: w_ra = r_i[IW-1:0];
            S_CM_J:                       w_ra = r_j[IW-1:0];
            default:                      w_ra = IW'(r_in.sprite_index);
        endcase
    end

    assign w_st  = r_stat[w_ra];
    assign w_sw  = r_sw[w_ra];
    assign w_sh  = r_sh[w_ra];
    assign w_ss  = r_ss[w_ra];
    assign w_sst = r_st[w_ra];
    assign w_buf = r_buf[w_ra];
    assign w_ers = r_ers[w_ra];
    assign w_idx_ok = (6'(i_in.sprite_index) < 6'(SPRITE_COUNT));

    // shared clamp unit
    logic signed [15:0] w_cv;
    logic [15:0]        w_cmap;
    logic [7:0]         w_csz;
    logic [15:0]        w_cpos;

    always_comb begin
        unique case (r_state)
            S_EN_S:  begin w_cv = r_in.pos_s; w_cmap = r_mapw; w_csz = r_in.size_w; end
            S_EN_T:  begin w_cv = r_in.pos_t; w_cmap = r_maph; w_csz = r_in.size_h; end
            S_MV_S:  begin w_cv = r_in.pos_s; w_cmap = r_mapw; w_csz = w_sw; end
            default: begin w_cv = r_in.pos_t; w_cmap = r_maph; w_csz = w_sh; end
        endcase
    end

    sdrt_clamp u_clamp (
        .i_v    (w_cv),
        .i_map  (w_cmap),
        .i_size (w_csz),
        .o_pos  (w_cpos)
    );

    // move deltas
    logic signed [16:0] w_ds, w_dt;
    assign w_ds = $signed({1'b0, r_s}) - $signed({1'b0, w_ss});
    assign w_dt = $signed({1'b0, r_t}) - $signed({1'b0, w_sst});

    // dirty rect hit test against entry r_i
    logic signed [17:0] w_rgt, w_bot, w_ps, w_pt;
    logic               w_dhit;
    always_comb begin
        w_ps  = {{2{r_in.pos_s[15]}}, r_in.pos_s};
        w_pt  = {{2{r_in.pos_t[15]}}, r_in.pos_t};
        w_rgt = w_ps + $signed({10'd0, r_in.size_w}) - 18'sd1;
        w_bot = w_pt + $signed({10'd0, r_in.size_h}) - 18'sd1;
        w_dhit = (w_st == ST_ACTIVE) &&
                 ($signed({2'b00, w_ss}) < w_rgt) &&
                 ($signed({2'b00, w_ss} + {10'd0, w_sw}) > w_ps) &&
                 ($signed({2'b00, w_sst}) < w_bot) &&
                 ($signed({2'b00, w_sst} + {10'd0, w_sh}) > w_pt);
    end

    // rectangle staging for commit
    logic  w_slot_free, w_stage_ok, w_room;
    t_out  w_new;
    assign w_slot_free = !r_out_v || i_out_ready;
    assign w_stage_ok  = !r_pend_v || w_slot_free;
    assign w_room      = (r_cnt < 5'(MAX_RESULTS));

    always_comb begin
        w_new             = '0;
        w_new.rect_sprite = 3'(r_i);
        if (r_state == S_CM_E) begin
            w_new.rect_kind = RK_ERASE;
            w_new.rect_s    = w_ers.s;
            w_new.rect_t    = w_ers.t;
            w_new.rect_w    = w_ers.w;
            w_new.rect_h    = w_ers.h;
        end else begin
            w_new.rect_kind = RK_DRAW;
            w_new.rect_s    = w_buf.s;
            w_new.rect_t    = w_buf.t;
            w_new.rect_w    = w_buf.w;
            w_new.rect_h    = w_buf.h;
        end
    end

    logic w_need_e, w_need_d;
    assign w_need_e = (w_st == ST_POSITIONING) || (w_st == ST_DISABLING);
    assign w_need_d = (w_st == ST_POSITIONING) || (w_st == ST_MOVING);

    // a word enters the output register: staged rect pushed out, or final word
    logic w_ld_e, w_ld_d, w_push;
    assign w_ld_e = (r_state == S_CM_E) && (r_i != LAST_I) && w_need_e && w_room &&
                    w_stage_ok;
    assign w_ld_d = (r_state == S_CM_D) && w_need_d && w_room && w_stage_ok;
    assign w_push = ((w_ld_e || w_ld_d) && r_pend_v) ||
                    ((r_state == S_FIN) && w_slot_free);

    // final word: last staged rect, or the plain acknowledge
    t_out w_fin;
    always_comb begin
        if (r_pend_v) begin
            w_fin = r_pend;
        end else begin
            w_fin          = '0;
            w_fin.accepted = r_acc;
            w_fin.out_s    = r_os;
            w_fin.out_t    = r_ot;
        end
        w_fin.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_out_v  <= 1'b0;
            r_pend_v <= 1'b0;
            r_mapw   <= MAPW_RST;
            r_maph   <= MAPH_RST;
            for (int k = 0; k < SPRITE_COUNT; k++) begin
                r_stat[k] <= ST_INACTIVE;
            end
        end else begin
            if (w_push) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_MAP_W: r_mapw <= i_cfg_data;
                    CFG_MAP_H: r_maph <= i_cfg_data;
                    default:   ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in  <= i_in;
                        r_acc <= 1'b0;
                        r_os  <= 16'd0;
                        r_ot  <= 16'd0;
                        r_i   <= '0;
                        r_cnt <= '0;
                        unique case (i_in.command)
                            CMD_ENABLE:  r_state <= w_idx_ok ? S_EN_S : S_FIN;
                            CMD_DISABLE: r_state <= w_idx_ok ? S_DIS  : S_FIN;
                            CMD_IMAGE:   r_state <= w_idx_ok ? S_IMG  : S_FIN;
                            CMD_MOVE:    r_state <= w_idx_ok ? S_MV_S : S_FIN;
                            CMD_DIRTY:   r_state <= S_DR;
                            CMD_COMMIT:  r_state <= S_CM_I;
                            default:     r_state <= S_FIN;
                        endcase
                    end
                end

                S_EN_S: begin
                    if (w_st != ST_INACTIVE) begin
                        r_acc   <= (w_st == ST_MOVING);
                        r_state <= S_FIN;
                    end else begin
                        r_s     <= w_cpos;
                        r_state <= S_EN_T;
                    end
                end
                S_EN_T: begin
                    r_t     <= w_cpos;
                    r_state <= S_EN_WR;
                end
                S_EN_WR: begin
                    r_sw[w_ra]  <= r_in.size_w;
                    r_sh[w_ra]  <= r_in.size_h;
                    r_ss[w_ra]  <= r_s;
                    r_st[w_ra]  <= r_t;
                    r_buf[w_ra] <= '{s: r_s & EVEN_MASK, t: r_t,
                                     w: span_w(r_s, r_s, r_in.size_w),
                                     h: {1'b0, r_in.size_h}};
                    if (r_in.image_handle != 16'd0) begin
                        r_stat[w_ra] <= ST_MOVING;
                        r_acc        <= 1'b1;
                    end
                    r_state <= S_FIN;
                end

                S_DIS: begin
                    if (w_st >= ST_ACTIVE) begin
                        r_stat[w_ra] <= ST_DISABLING;
                        r_ers[w_ra]  <= w_buf;
                    end
                    r_state <= S_FIN;
                end

                S_IMG: begin
                    if (w_st == ST_ACTIVE) begin
                        r_stat[w_ra] <= ST_MOVING;
                        r_buf[w_ra]  <= '{s: w_ss & EVEN_MASK, t: w_sst,
                                          w: span_w(w_ss, w_ss, w_sw), h: {1'b0, w_sh}};
                    end
                    r_state <= S_FIN;
                end

                S_MV_S: begin
                    if (w_st < ST_ACTIVE) begin
                        r_state <= S_FIN;
                    end else begin
                        r_s     <= w_cpos;
                        r_state <= S_MV_T;
                    end
                end
                S_MV_T: begin
                    r_t     <= w_cpos;
                    r_state <= S_MV_D;
                end
                S_MV_D: begin
                    r_skip  <= (r_s == w_ss) && (r_t == w_sst) && (w_st != ST_MOVING);
                    r_near  <= (w_ds <= MM) && (w_ds >= -MM) && (w_dt <= MM) && (w_dt >= -MM);
                    r_dsle  <= (w_ds <= 17'sd0);
                    r_dtle  <= (w_dt <= 17'sd0);
                    r_state <= S_MV_X;
                end
                S_MV_X: begin
                    if (!r_skip) begin
                        if (r_near) begin
                            if (r_dsle) begin
                                r_buf[w_ra].s <= r_s & EVEN_MASK;
                                r_buf[w_ra].w <= span_w(r_s, w_ss, w_sw);
                            end else begin
                                r_buf[w_ra].s <= w_ss & EVEN_MASK;
                                r_buf[w_ra].w <= span_w(w_ss, r_s, w_sw);
                            end
                        end else begin
                            r_ers[w_ra].s <= w_ss & EVEN_MASK;
                            r_ers[w_ra].w <= span_w(w_ss, w_ss, w_sw);
                            r_buf[w_ra].s <= r_s & EVEN_MASK;
                            r_buf[w_ra].w <= span_w(r_s, r_s, w_sw);
                        end
                    end
                    r_state <= S_MV_Y;
                end
                S_MV_Y: begin
                    if (!r_skip) begin
                        if (r_near) begin
                            r_stat[w_ra] <= ST_MOVING;
                            if (r_dtle) begin
                                r_buf[w_ra].t <= r_t;
                                r_buf[w_ra].h <= 9'({1'b0, w_sst} + {9'd0, w_sh} - {1'b0, r_t});
                            end else begin
                                r_buf[w_ra].t <= w_sst;
                                r_buf[w_ra].h <= 9'({1'b0, r_t} + {9'd0, w_sh} - {1'b0, w_sst});
                            end
                        end else begin
                            r_stat[w_ra]  <= ST_POSITIONING;
                            r_ers[w_ra].t <= w_sst;
                            r_ers[w_ra].h <= {1'b0, w_sh};
                            r_buf[w_ra].t <= r_t;
                            r_buf[w_ra].h <= {1'b0, w_sh};
                        end
                        r_ss[w_ra] <= r_s;
                        r_st[w_ra] <= r_t;
                    end
                    r_acc   <= 1'b1;
                    r_os    <= r_s;
                    r_ot    <= r_t;
                    r_state <= S_FIN;
                end

                S_DR: begin
                    if (r_i == LAST_I) begin
                        r_state <= S_FIN;
                    end else begin
                        if (w_dhit) begin
                            r_stat[w_ra] <= ST_MOVING;
                            r_buf[w_ra]  <= '{s: w_ss & EVEN_MASK, t: w_sst,
                                              w: span_w(w_ss, w_ss, w_sw), h: {1'b0, w_sh}};
                        end
                        r_i <= r_i + 1'b1;
                    end
                end

                // commit, pass one: active sprites under a lower shown buffer
                S_CM_I: begin
                    if (r_i == LAST_I) begin
                        r_i     <= '0;
                        r_state <= S_CM_E;
                    end else if (w_st == ST_ACTIVE) begin
                        r_cur   <= w_buf;
                        r_j     <= '0;
                        r_state <= S_CM_J;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_CM_J: begin
                    if (r_j == r_i) begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_CM_I;
                    end else if ((w_st >= ST_ACTIVE) && rect_hit(w_buf, r_cur)) begin
                        r_stat[r_i[IW-1:0]] <= ST_MOVING;
                        r_i     <= r_i + 1'b1;
                        r_state <= S_CM_I;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end

                // commit, pass two: emit rectangles and settle
                S_CM_E: begin
                    if (r_i == LAST_I) begin
                        r_state <= S_FIN;
                    end else if (w_need_e && w_room) begin
                        if (w_stage_ok) begin
                            if (r_pend_v) begin
                                r_out <= r_pend;
                            end
                            r_pend   <= w_new;
                            r_pend_v <= 1'b1;
                            r_cnt    <= r_cnt + 1'b1;
                            r_state  <= S_CM_D;
                        end
                    end else begin
                        r_state <= S_CM_D;
                    end
                end
                S_CM_D: begin
                    if (w_need_d) begin
                        if (!w_room) begin
                            r_stat[w_ra] <= ST_ACTIVE;
                            r_i          <= r_i + 1'b1;
                            r_state      <= S_CM_E;
                        end else if (w_stage_ok) begin
                            if (r_pend_v) begin
                                r_out <= r_pend;
                            end
                            r_pend       <= w_new;
                            r_pend_v     <= 1'b1;
                            r_cnt        <= r_cnt + 1'b1;
                            r_stat[w_ra] <= ST_ACTIVE;
                            r_i          <= r_i + 1'b1;
                            r_state      <= S_CM_E;
                        end
                    end else begin
                        if (w_st == ST_DISABLING) begin
                            r_stat[w_ra] <= ST_INACTIVE;
                        end
                        r_i     <= r_i + 1'b1;
                        r_state <= S_CM_E;
                    end
                end

                // final word of the command, flagged last
                S_FIN: begin
                    if (w_slot_free) begin
                        r_out    <= w_fin;
                        r_pend_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_v;
    assign o_out       = r_out;
    // map registers change only between commands
    assign o_cfg_ready = (r_state == S_IDLE);

endmodule

### rtl/sdrt_clamp.sv
// ----------------------------------------------------------------------------
// sdrt_clamp
// Shared position clamp: limits a signed position to [0, map - size].
// ----------------------------------------------------------------------------
module sdrt_clamp (
    input  logic signed [15:0] i_v,
    input  logic [15:0]        i_map,
    input  logic [7:0]         i_size,
    output logic [15:0]        o_pos
);
    logic signed [16:0] w_lim;
    logic [15:0]        w_lim_sat;

    always_comb begin
        w_lim     = $signed({1'b0, i_map}) - $signed({9'd0, i_size});
        w_lim_sat = w_lim[16] ? 16'd0 : w_lim[15:0];
        if (i_v[15]) begin
            o_pos = 16'd0;
        end else if ({1'b0, i_v} > {1'b0, w_lim_sat}) begin
            o_pos = w_lim_sat;
        end else begin
            o_pos = i_v;
        end
    end
endmodule

### rtl/sdrt_checker.sv
// ----------------------------------------------------------------------------
// sdrt_checker
// Port-level checks of the tracker, bound to the top level.
// ----------------------------------------------------------------------------
module sdrt_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input sdrt_pkg::t_in                  i_in,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input sdrt_pkg::t_out                 o_out,
    input logic                           i_cfg_valid,
    input logic                           o_cfg_ready,
    input logic [sdrt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input logic [15:0]                    i_cfg_data
);
    import sdrt_pkg::*;

    // stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("output word changed while stalled");

    // one command in flight
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready after accepting a command");

    a_empty_rect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.rect_kind == RK_NONE) |->
            (o_out.rect_s == 16'd0) && (o_out.rect_w == 9'd0) && (o_out.rect_h == 9'd0))
        else $error("empty word carries rectangle data");

    a_rect_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.rect_kind != RK_NONE) |->
            !o_out.rect_s[0] && !o_out.accepted)
        else $error("rectangle word malformed");

endmodule

bind sprite_dirty_rect_tracker_core sdrt_checker u_sdrt_checker (.*);

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sprite dirty-rectangle tracker. Directed rows
// walk the corner cases, then random command streams run against a predictor
// of the sprite table, under several map sizes and random stalls on both
// handshake sides.
// ----------------------------------------------------------------------------
module tb_top;
    import sdrt_pkg::*;

    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;
    localparam int         STALL_LIMIT = 5000;
    localparam int         DRAIN_CYCLES = 120;

    typedef struct {
        int s;
        int t;
        int w;
        int h;
    } box_t;

    typedef struct {
        t_in  cmd;
        bit   typed;
        t_out word;
    } row_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_in                  i_in;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_out                 o_out;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [15:0]          i_cfg_data;

    sprite_dirty_rect_tracker_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // shadow of the sprite table
    int      map_w, map_h;
    t_status sprite_st [SDRT_SPRITES];
    int      spr_s [SDRT_SPRITES], spr_t [SDRT_SPRITES];
    int      spr_w [SDRT_SPRITES], spr_h [SDRT_SPRITES];
    box_t    draw_box [SDRT_SPRITES];
    box_t    erase_box [SDRT_SPRITES];

    t_out    pending_words[$];
    row_t    rows[$];
    int      errors;
    int      quiet_cycles;
    bit      calm;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic bit idle_now();
        return !calm && ($urandom_range(99) < 38);
    endfunction

    // ---------------------------------------------------------------- predictor
    function automatic int clamp_to_map(int v, int lim_map, int size);
        int lim;
        lim = lim_map - size;
        if (lim < 0) lim = 0;
        if (v < 0) return 0;
        if (v > lim) return lim;
        return v;
    endfunction

    function automatic box_t even_span(int s, int t, int w, int h);
        box_t b;
        b.s = s & 32'hFFFE;
        b.w = ((s + w + 1) & ~32'd1) - b.s;
        b.t = t;
        b.h = h;
        return b;
    endfunction

    function automatic t_out make_word(bit acc, int os, int ot, logic [1:0] kind,
                                       int spr, box_t b);
        t_out o;
        o.accepted    = acc;
        o.out_s       = os[15:0];
        o.out_t       = ot[15:0];
        o.rect_kind   = kind;
        o.rect_sprite = spr[2:0];
        o.rect_s      = (kind == RK_NONE) ? 16'd0 : b.s[15:0];
        o.rect_t      = (kind == RK_NONE) ? 16'd0 : b.t[15:0];
        o.rect_w      = (kind == RK_NONE) ? 9'd0 : b.w[8:0];
        o.rect_h      = (kind == RK_NONE) ? 9'd0 : b.h[8:0];
        o.last        = 1'b0;
        return o;
    endfunction

    function automatic bit boxes_overlap(box_t a, box_t b);
        return a.s < b.s + b.w && a.s + a.w > b.s && a.t < b.t + b.h && a.t + a.h > b.t;
    endfunction

    function automatic void apply_move(int i, int ns, int nt);
        int s, t, os, ot, ds, dt;
        s  = clamp_to_map(ns, map_w, spr_w[i]);
        t  = clamp_to_map(nt, map_h, spr_h[i]);
        os = spr_s[i];
        ot = spr_t[i];
        if (s == os && t == ot && sprite_st[i] != ST_MOVING) return;
        ds = s - os;
        dt = t - ot;
        if (ds <= SDRT_MARGIN && ds >= -SDRT_MARGIN && dt <= SDRT_MARGIN &&
            dt >= -SDRT_MARGIN) begin
            // short hop: one merged rectangle covers old and new area
            sprite_st[i] = ST_MOVING;
            if (ds <= 0) begin
                draw_box[i].s = s & 32'hFFFE;
                draw_box[i].w = ((os + spr_w[i] + 1) & ~32'd1) - draw_box[i].s;
            end else begin
                draw_box[i].s = os & 32'hFFFE;
                draw_box[i].w = ((s + spr_w[i] + 1) & ~32'd1) - draw_box[i].s;
            end
            if (dt <= 0) begin
                draw_box[i].t = t;
                draw_box[i].h = ot + spr_h[i] - t;
            end else begin
                draw_box[i].t = ot;
                draw_box[i].h = t + spr_h[i] - ot;
            end
        end else begin
            sprite_st[i] = ST_POSITIONING;
            erase_box[i] = even_span(os, ot, spr_w[i], spr_h[i]);
            draw_box[i]  = even_span(s, t, spr_w[i], spr_h[i]);
        end
        spr_s[i] = s;
        spr_t[i] = t;
    endfunction

    // returns the words one command produces and updates the shadow table
    function automatic void predict_words(t_in x, ref t_out words[$]);
        int   i, ps, pt, w, h, right, bottom;
        bit   acc;
        int   os, ot;
        box_t none;
        t_status cur;
        none = '{0, 0, 0, 0};
        i = x.sprite_index;
        ps = x.pos_s;
        pt = x.pos_t;
        w = x.size_w;
        h = x.size_h;
        acc = 1'b0;
        os = 0;
        ot = 0;
        words.delete();
        case (x.command)
            CMD_ENABLE: begin
                if (sprite_st[i] == ST_INACTIVE) begin
                    spr_w[i] = w;
                    spr_h[i] = h;
                    spr_s[i] = clamp_to_map(ps, map_w, w);
                    spr_t[i] = clamp_to_map(pt, map_h, h);
                    draw_box[i] = even_span(spr_s[i], spr_t[i], w, h);
                    if (x.image_handle != 16'd0) sprite_st[i] = ST_MOVING;
                end
                acc = (sprite_st[i] == ST_MOVING);
            end
            CMD_DISABLE: begin
                if (sprite_st[i] >= ST_ACTIVE) begin
                    sprite_st[i] = ST_DISABLING;
                    erase_box[i] = draw_box[i];
                end
            end
            CMD_IMAGE: begin
                if (sprite_st[i] == ST_ACTIVE) begin
                    sprite_st[i] = ST_MOVING;
                    draw_box[i] = even_span(spr_s[i], spr_t[i], spr_w[i], spr_h[i]);
                end
            end
            CMD_MOVE: begin
                if (sprite_st[i] >= ST_ACTIVE) begin
                    apply_move(i, ps, pt);
                    acc = 1'b1;
                    os = spr_s[i];
                    ot = spr_t[i];
                end
            end
            CMD_DIRTY: begin
                right = ps + w - 1;
                bottom = pt + h - 1;
                for (int k = 0; k < SDRT_SPRITES; k++) begin
                    if (sprite_st[k] == ST_ACTIVE && spr_s[k] < right &&
                        spr_s[k] + spr_w[k] > ps && spr_t[k] < bottom &&
                        spr_t[k] + spr_h[k] > pt) begin
                        sprite_st[k] = ST_MOVING;
                        draw_box[k] = even_span(spr_s[k], spr_t[k], spr_w[k], spr_h[k]);
                    end
                end
            end
            CMD_COMMIT: begin
                // active sprites under a lower-index shown sprite get redrawn
                for (int a = 0; a < SDRT_SPRITES; a++) begin
                    if (sprite_st[a] != ST_ACTIVE) continue;
                    for (int b = 0; b < a; b++) begin
                        if (sprite_st[b] >= ST_ACTIVE &&
                            boxes_overlap(draw_box[b], draw_box[a])) begin
                            sprite_st[a] = ST_MOVING;
                            break;
                        end
                    end
                end
                for (int a = 0; a < SDRT_SPRITES; a++) begin
                    cur = sprite_st[a];
                    if ((cur == ST_POSITIONING || cur == ST_DISABLING) &&
                        words.size() < MAX_RESULTS)
                        words.push_back(make_word(0, 0, 0, RK_ERASE, a, erase_box[a]));
                    if (cur == ST_POSITIONING || cur == ST_MOVING) begin
                        if (words.size() < MAX_RESULTS)
                            words.push_back(make_word(0, 0, 0, RK_DRAW, a, draw_box[a]));
                        sprite_st[a] = ST_ACTIVE;
                    end else if (cur == ST_DISABLING) begin
                        sprite_st[a] = ST_INACTIVE;
                    end
                end
                if (words.size() == 0) words.push_back(make_word(0, 0, 0, RK_NONE, 0, none));
                words[words.size()-1].last = 1'b1;
                return;
            end
            default: ;
        endcase
        words.push_back(make_word(acc, os, ot, RK_NONE, 0, none));
        words[0].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------- checking
    task automatic report(string field, longint got, longint want);
        $display("mismatch %s: got %0d want %0d at %0t", field, got, want, $realtime);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_words.size() == 0) begin
                report("extra word", 1, 0);
            end else begin
                want = pending_words.pop_front();
                if (o_out.accepted !== want.accepted)
                    report("accepted", o_out.accepted, want.accepted);
                if (o_out.out_s !== want.out_s) report("out_s", o_out.out_s, want.out_s);
                if (o_out.out_t !== want.out_t) report("out_t", o_out.out_t, want.out_t);
                if (o_out.rect_kind !== want.rect_kind)
                    report("rect_kind", o_out.rect_kind, want.rect_kind);
                if (o_out.rect_sprite !== want.rect_sprite)
                    report("rect_sprite", o_out.rect_sprite, want.rect_sprite);
                if (o_out.rect_s !== want.rect_s) report("rect_s", o_out.rect_s, want.rect_s);
                if (o_out.rect_t !== want.rect_t) report("rect_t", o_out.rect_t, want.rect_t);
                if (o_out.rect_w !== want.rect_w) report("rect_w", o_out.rect_w, want.rect_w);
                if (o_out.rect_h !== want.rect_h) report("rect_h", o_out.rect_h, want.rect_h);
                if (o_out.last !== want.last) report("last", o_out.last, want.last);
            end
        end
    end

    // receiver side stalls
    always @(negedge i_clk) i_out_ready = !idle_now();

    // watchdog: cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ---------------------------------------------------------------- driving
    function automatic t_in mk(logic [2:0] c, int idx, int ps, int pt, int w, int h,
                               int img);
        t_in x;
        x.command = c;
        x.sprite_index = idx[2:0];
        x.pos_s = ps[15:0];
        x.pos_t = pt[15:0];
        x.size_w = w[7:0];
        x.size_h = h[7:0];
        x.image_handle = img[15:0];
        return x;
    endfunction

    function automatic t_out ack_word(bit acc, int os, int ot);
        t_out o;
        o = make_word(acc, os, ot, RK_NONE, 0, '{0, 0, 0, 0});
        o.last = 1'b1;
        return o;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(t_in x, bit typed, t_out typed_word);
        t_out words[$];
        while (idle_now()) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in = x;
        do @(posedge i_clk); while (!o_in_ready);
        predict_words(x, words);
        if (typed && words.size() == 1) words[0] = typed_word;
        foreach (words[k]) pending_words.push_back(words[k]);
        @(negedge i_clk);
    endtask

    task automatic set_map(int w, int h);
        i_in_valid = 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        for (int r = 0; r < 2; r++) begin
            @(negedge i_clk);
            i_cfg_valid = 1'b1;
            i_cfg_index = (r == 0) ? CFG_MAP_W : CFG_MAP_H;
            i_cfg_data  = (r == 0) ? w[15:0] : h[15:0];
            do @(posedge i_clk); while (!o_cfg_ready);
            @(negedge i_clk);
            i_cfg_valid = 1'b0;
        end
        map_w = w;
        map_h = h;
    endtask

    // mostly well-formed traffic: enable, nudge, commit, with noise mixed in
    function automatic t_in random_cmd();
        int idx, pick, ps, pt, w, h, img;
        logic [2:0] c;
        idx  = $urandom_range(SDRT_SPRITES - 1);
        pick = $urandom_range(99);
        w    = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(1, 40);
        h    = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(1, 40);
        img  = ($urandom_range(7) == 0) ? 0 : $urandom_range(65535);
        ps   = $urandom_range(map_w + 20) - 10;
        pt   = $urandom_range(map_h + 20) - 10;
        if ($urandom_range(9) == 0) begin
            ps = $urandom_range(65535);
            pt = $urandom_range(65535);
        end
        if (pick < 16)      c = CMD_ENABLE;
        else if (pick < 24) c = CMD_DISABLE;
        else if (pick < 33) c = CMD_IMAGE;
        else if (pick < 63) c = CMD_MOVE;
        else if (pick < 74) c = CMD_DIRTY;
        else if (pick < 96) c = CMD_COMMIT;
        else                c = $urandom_range(1) ? CMD_RSVD6 : CMD_RSVD7;
        if (c == CMD_MOVE && sprite_st[idx] >= ST_ACTIVE && $urandom_range(9) < 7) begin
            ps = spr_s[idx] + $urandom_range(24) - 12;
            pt = spr_t[idx] + $urandom_range(24) - 12;
        end
        return mk(c, idx, ps, pt, w, h, img);
    endfunction

    initial begin
        t_out dummy;
        errors = 0;
        calm = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_MAP_W;
        i_cfg_data = 16'd0;
        map_w = MAPW_RST;
        map_h = MAPH_RST;
        foreach (sprite_st[k]) sprite_st[k] = ST_INACTIVE;
        dummy = ack_word(0, 0, 0);
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed rows at the reset map of 160 x 100
        rows.push_back('{mk(CMD_ENABLE, 0, -32768, -32768, 255, 255, 0), 1, ack_word(0, 0, 0)});
        rows.push_back('{mk(CMD_ENABLE, 0, 32767, 32767, 16, 8, 65535), 1, ack_word(1, 0, 0)});
        rows.push_back('{mk(CMD_ENABLE, 0, 0, 0, 4, 4, 7), 1, ack_word(1, 0, 0)});
        rows.push_back('{mk(CMD_COMMIT, 0, 0, 0, 0, 0, 0), 0, dummy});
        rows.push_back('{mk(CMD_MOVE, 0, 140, 90, 0, 0, 0), 1, ack_word(1, 140, 90)});
        rows.push_back('{mk(CMD_MOVE, 0, -1, -1, 0, 0, 0), 1, ack_word(1, 0, 0)});
        rows.push_back('{mk(CMD_ENABLE, 1, 3, 5, 7, 9, 1), 0, dummy});
        rows.push_back('{mk(CMD_ENABLE, 2, 1, 1, 255, 255, 2), 0, dummy});
        rows.push_back('{mk(CMD_COMMIT, 0, 0, 0, 0, 0, 0), 0, dummy});
        rows.push_back('{mk(CMD_COMMIT, 0, 0, 0, 0, 0, 0), 0, dummy});
        rows.push_back('{mk(CMD_DIRTY, 0, -5, -5, 255, 255, 0), 1, ack_word(0, 0, 0)});
        rows.push_back('{mk(CMD_IMAGE, 3, 0, 0, 0, 0, 5), 1, ack_word(0, 0, 0)});
        rows.push_back('{mk(CMD_IMAGE, 1, 0, 0, 0, 0, 0), 1, ack_word(0, 0, 0)});
        rows.push_back('{mk(CMD_DISABLE, 0, 0, 0, 0, 0, 0), 1, ack_word(0, 0, 0)});
        rows.push_back('{mk(CMD_DISABLE, 4, 0, 0, 0, 0, 0), 1, ack_word(0, 0, 0)});
        rows.push_back('{mk(CMD_RSVD6, 5, 1, 1, 1, 1, 1), 1, ack_word(0, 0, 0)});
        rows.push_back('{mk(CMD_RSVD7, 6, 2, 2, 2, 2, 2), 1, ack_word(0, 0, 0)});
        rows.push_back('{mk(CMD_COMMIT, 0, 0, 0, 0, 0, 0), 0, dummy});
        rows.push_back('{mk(CMD_ENABLE, 7, 0, 0, 0, 0, 9), 1, ack_word(1, 0, 0)});
        rows.push_back('{mk(CMD_COMMIT, 0, 0, 0, 0, 0, 0), 0, dummy});
        rows.push_back('{mk(CMD_MOVE, 7, 0, 0, 0, 0, 0), 1, ack_word(1, 0, 0)});
        rows.push_back('{mk(CMD_MOVE, 1, 12, 14, 0, 0, 0), 0, dummy});
        rows.push_back('{mk(CMD_DIRTY, 0, 32767, 32767, 0, 0, 0), 1, ack_word(0, 0, 0)});
        rows.push_back('{mk(CMD_COMMIT, 0, 0, 0, 0, 0, 0), 0, dummy});

        set_map(160, 100);
        foreach (rows[r]) send_word(rows[r].cmd, rows[r].typed, rows[r].word);

        // random phases, map extremes among them
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: set_map(16, 16);
                1: set_map(65520, 65520);
                2: set_map(320, 200);
                3: set_map($urandom_range(16, 400), $urandom_range(16, 300));
                default: set_map(160, 100);
            endcase
            calm = (ph == 2);
            @(negedge i_clk);
            for (int n = 0; n < 62; n++) send_word(random_cmd(), 0, dummy);
        end
        i_in_valid = 1'b0;

        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending_words.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### sprite_dirty_rect_tracker_core.f
rtl/sdrt_pkg.sv
rtl/sdrt_clamp.sv
rtl/sprite_dirty_rect_tracker_core.sv
rtl/sdrt_checker.sv
tb/sv/tb_top.sv
